// ----- sv/paas_pkg.sv -----
`default_nettype none

package paas_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;

   // DAC range limits
   localparam logic signed [17:0] DacTop    = 18'sd131071;
   localparam logic signed [17:0] DacBottom = -18'sd131072;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CURRENT_GOAL      = 3'd0,
      CSR_Z_GOAL            = 3'd1,
      CSR_Z_LOW_LIMIT       = 3'd2,
      CSR_Z_HIGH_RETRACT    = 3'd3,
      CSR_Z_STEP            = 3'd4,
      CSR_STEPPER_INCREMENT = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      FUNC_START  = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_STOP   = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ACT_IGNORED = 3'd0,
      ACT_STARTED = 3'd1,
      ACT_Z_STEP  = 3'd2,
      ACT_RETRACT = 3'd3,
      ACT_DONE    = 3'd4
   } action_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [23:0] current_sample;
   } req_word_type;

   typedef struct packed {
      logic signed [17:0] z_value;
      logic signed [15:0] stepper_request;
      logic [31:0]        iteration_count;
      logic               active;
      logic [2:0]         action;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- sv/probe_auto_approach_sequencer_core.sv -----
`default_nettype none

// Coarse-approach sequencer for a scanning probe. A start word clears the
// iteration count, moves z to z_high_retract and arms the run; a stop word
// disarms it. While armed, each current-sample word either ends the run
// (current and z both at goal), retracts z and requests one stepper increment
// (current at goal with z short of it, or z at the low limit), or moves z by
// z_step clipped to the 18-bit DAC range. Every request word yields exactly
// one response word. Throughput is one word per clock while req_ready is
// high: the decision is one add, a clip and three compares between the
// sequencer state registers and the response register. A two-entry response
// buffer (output register plus skid) lets a request be taken while an earlier
// response still waits; req_ready drops only when both are full. CSR writes
// are taken every cycle and must only come while idle.
module probe_auto_approach_sequencer_core
   import paas_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_word_type             req_word,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_word_type                  rsp_word,
   // CSR write channel
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   // ---- CSRs ----
   logic signed [23:0] current_goal_ff;
   logic signed [17:0] z_goal_ff;
   logic signed [17:0] z_low_limit_ff;
   logic signed [17:0] z_high_retract_ff;
   logic signed [17:0] z_step_ff;
   logic signed [15:0] stepper_increment_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         current_goal_ff      <= '0;
         z_goal_ff            <= '0;
         z_low_limit_ff       <= '0;
         z_high_retract_ff    <= '0;
         z_step_ff            <= '0;
         stepper_increment_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CURRENT_GOAL:      current_goal_ff      <= csr_wdata;
            CSR_Z_GOAL:            z_goal_ff            <= csr_wdata[17:0];
            CSR_Z_LOW_LIMIT:       z_low_limit_ff       <= csr_wdata[17:0];
            CSR_Z_HIGH_RETRACT:    z_high_retract_ff    <= csr_wdata[17:0];
            CSR_Z_STEP:            z_step_ff            <= csr_wdata[17:0];
            CSR_STEPPER_INCREMENT: stepper_increment_ff <= csr_wdata[15:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // ---- sequencer state ----
   logic signed [17:0] z_ff, z_in;
   logic [31:0]        iter_ff, iter_in;
   logic               armed_ff, armed_in;

   // ---- response buffer ----
   rsp_word_type out_ff, skid_ff;
   logic         out_valid_ff, skid_valid_ff;

   logic push, pop;
   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;
   assign pop       = out_valid_ff && rsp_ready;

   // ---- decision logic ----
   logic               reached, z_at_goal, z_at_low;
   logic signed [18:0] z_sum;
   logic signed [17:0] z_clip;
   logic signed [15:0] request;
   action_type         action;
   rsp_word_type       result;

   assign reached   = req_word.current_sample >= current_goal_ff;
   assign z_at_goal = z_ff >= z_goal_ff;
   assign z_at_low  = z_ff <= z_low_limit_ff;
   assign z_sum     = 19'(z_ff) + 19'(z_step_ff);

   always_comb begin
      if (z_sum > 19'(DacTop)) begin
         z_clip = DacTop;
      end else if (z_sum < 19'(DacBottom)) begin
         z_clip = DacBottom;
      end else begin
         z_clip = z_sum[17:0];
      end
   end

   always_comb begin
      z_in     = z_ff;
      iter_in  = iter_ff;
      armed_in = armed_ff;
      request  = '0;
      action   = ACT_IGNORED;
      case (req_word.func)
         FUNC_START: begin
            iter_in  = '0;
            z_in     = z_high_retract_ff;
            armed_in = 1'b1;
            action   = ACT_STARTED;
         end
         FUNC_STOP: begin
            armed_in = 1'b0;
            action   = ACT_DONE;
         end
         FUNC_SAMPLE: begin
            if (armed_ff) begin
               if (reached && z_at_goal) begin
                  armed_in = 1'b0;
                  action   = ACT_DONE;
               end else if (reached || z_at_low) begin
                  z_in    = z_high_retract_ff;
                  request = stepper_increment_ff;
                  iter_in = iter_ff + 32'd1;
                  action  = ACT_RETRACT;
               end else begin
                  z_in   = z_clip;
                  action = ACT_Z_STEP;
               end
            end
         end
         default: ;  // unused code: no effect
      endcase
   end

   assign result.z_value         = z_in;
   assign result.stepper_request = request;
   assign result.iteration_count = iter_in;
   assign result.active          = armed_in;
   assign result.action          = action;

   always_ff @(posedge clock) begin
      if (reset) begin
         z_ff     <= '0;
         iter_ff  <= '0;
         armed_ff <= 1'b0;
      end else if (push) begin
         z_ff     <= z_in;
         iter_ff  <= iter_in;
         armed_ff <= armed_in;
      end
   end

   // Output register refills from skid first, then from a new result.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= result;
         end
      end else if (push) begin
         skid_ff <= result;
      end
   end

   // ---- assertions ----
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while output register is empty");

   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      push && req_word.func == FUNC_START |=> armed_ff && iter_ff == '0)
      else $error("start did not arm or clear iterations");

   a_stop_disarms: assert property (@(posedge clock) disable iff (reset)
      push && req_word.func == FUNC_STOP |=> !armed_ff)
      else $error("stop did not disarm");

   a_retract_counts: assert property (@(posedge clock) disable iff (reset)
      push && action == ACT_RETRACT |=>
         iter_ff == $past(iter_ff) + 32'd1 && z_ff == z_high_retract_ff)
      else $error("retract did not count or reload z");

   a_no_move_state: assert property (@(posedge clock) disable iff (reset)
      push && action == ACT_IGNORED |=> $stable(z_ff) && $stable(iter_ff))
      else $error("ignored word changed state");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

// Bench for the coarse-approach sequencer core.
module tb;
   import paas_pkg::*;

   // Code 3 has no meaning in the func field; the core must ignore it.
   localparam logic [1:0] FuncUnused = 2'd3;
   localparam int LongHoldCycles = 300;
   localparam int RandomPhases = 8;
   localparam int ItemsPerPhase = 55;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_word_type             req_word  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_word_type             rsp_word;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = CSR_CURRENT_GOAL;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   probe_auto_approach_sequencer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Request words waiting for the driver, and the responses the
   // sequencer owes us, oldest first.
   req_word_type approach_req_q[$];
   rsp_word_type approach_rsp_q[$];

   // Flow-control knobs, percent of cycles spent idle / stalled.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // Long receiver hold-off: stimulus raises the request, the receiver
   // process owns the countdown.
   bit hold_wanted = 1'b0;
   bit hold_done   = 1'b0;
   int hold_left   = 0;

   bit req_taken = 1'b0;
   int mismatch_count = 0;
   int rsp_count = 0;

   // Goal used by the stimulus to aim samples around the threshold.
   logic signed [23:0] stim_goal = '0;

   // ------------------------------------------------------------------
   // Predictor: own copy of the CSRs and sequencer state.
   // ------------------------------------------------------------------
   logic signed [23:0] goal_level   = '0;
   logic signed [17:0] z_target     = '0;
   logic signed [17:0] z_floor      = '0;
   logic signed [17:0] z_retract    = '0;
   logic signed [17:0] z_delta      = '0;
   logic signed [15:0] stepper_incr = '0;

   logic signed [17:0] z_now     = '0;
   logic [31:0]        iter_now  = '0;
   logic               armed_now = 1'b0;

   function automatic void apply_csr(csr_index_type idx, logic [CsrDataWidth-1:0] data);
      case (idx)
         CSR_CURRENT_GOAL:      goal_level   = data[23:0];
         CSR_Z_GOAL:            z_target     = data[17:0];
         CSR_Z_LOW_LIMIT:       z_floor      = data[17:0];
         CSR_Z_HIGH_RETRACT:    z_retract    = data[17:0];
         CSR_Z_STEP:            z_delta      = data[17:0];
         CSR_STEPPER_INCREMENT: stepper_incr = data[15:0];
         default: ;
      endcase
   endfunction

   // Advances the sequencer state by one request word and returns the
   // response word it should produce.
   function automatic rsp_word_type sequence_step(req_word_type w);
      rsp_word_type       r;
      logic               reached;
      logic signed [18:0] z_sum;
      r = '0;
      r.action = ACT_IGNORED;
      case (w.func)
         FUNC_START: begin
            iter_now  = '0;
            z_now     = z_retract;   // limits already inside DAC range
            armed_now = 1'b1;
            r.action  = ACT_STARTED;
         end
         FUNC_STOP: begin
            armed_now = 1'b0;
            r.action  = ACT_DONE;
         end
         FUNC_SAMPLE: begin
            if (armed_now) begin
               reached = (w.current_sample >= goal_level);
               if (reached && z_now >= z_target) begin
                  armed_now = 1'b0;
                  r.action  = ACT_DONE;
               end else if (reached || z_now <= z_floor) begin
                  z_now             = z_retract;
                  r.stepper_request = stepper_incr;
                  iter_now          = iter_now + 32'd1;
                  r.action          = ACT_RETRACT;
               end else begin
                  // 19-bit sum, then clip to the DAC range
                  z_sum = z_now + z_delta;
                  if (z_sum > DacTop)
                     z_now = DacTop;
                  else if (z_sum < DacBottom)
                     z_now = DacBottom;
                  else
                     z_now = z_sum[17:0];
                  r.action = ACT_Z_STEP;
               end
            end
         end
         default: ;   // unused code: no state change
      endcase
      r.z_value         = z_now;
      r.iteration_count = iter_now;
      r.active          = armed_now;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents queued words on the falling edge, holds a word
   // until it is taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (approach_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_word  <= approach_req_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus the one long hold-off.
   always @(negedge clock) begin
      if (hold_wanted && !hold_done) begin
         hold_left = LongHoldCycles;
         hold_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predicts on every accepted request, checks every accepted
   // response against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      req_taken = req_valid && req_ready;
      if (!reset) begin
         if (req_taken)
            approach_rsp_q.push_back(sequence_step(req_word));
         if (rsp_valid && rsp_ready) begin
            rsp_count = rsp_count + 1;
            if (approach_rsp_q.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("response %0d arrived with nothing pending: z %0d action %0d",
                           rsp_count, rsp_word.z_value, rsp_word.action);
            end else begin
               want = approach_rsp_q.pop_front();
               if (rsp_word.z_value !== want.z_value
                   || rsp_word.stepper_request !== want.stepper_request
                   || rsp_word.iteration_count !== want.iteration_count
                   || rsp_word.active !== want.active
                   || rsp_word.action !== want.action) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10) begin
                     $write("response %0d (expected/actual): z %0d/%0d step %0d/%0d ",
                            rsp_count, want.z_value, rsp_word.z_value,
                            want.stepper_request, rsp_word.stepper_request);
                     $display("iter %0d/%0d active %0b/%0b action %0d/%0d",
                              want.iteration_count, rsp_word.iteration_count,
                              want.active, rsp_word.active, want.action, rsp_word.action);
                  end
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_word(logic [1:0] f, logic signed [23:0] s);
      req_word_type w;
      w.func           = f;
      w.current_sample = s;
      approach_req_q.push_back(w);
   endtask

   // Keeps csr_valid high across back-to-back writes; caller lowers it.
   task automatic csr_write(csr_index_type idx, logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
   endtask

   task automatic program_settings(logic signed [23:0] goal, logic signed [17:0] zg,
                                   logic signed [17:0] zl, logic signed [17:0] zh,
                                   logic signed [17:0] zs, logic signed [15:0] inc);
      stim_goal = goal;
      csr_write(CSR_CURRENT_GOAL, CsrDataWidth'(goal));
      csr_write(CSR_Z_GOAL, CsrDataWidth'(zg));
      csr_write(CSR_Z_LOW_LIMIT, CsrDataWidth'(zl));
      csr_write(CSR_Z_HIGH_RETRACT, CsrDataWidth'(zh));
      csr_write(CSR_Z_STEP, CsrDataWidth'(zs));
      csr_write(CSR_STEPPER_INCREMENT, CsrDataWidth'(inc));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Either fully random CSRs, or a sane approach profile: retract above
   // the floor, z goal in between, z walking down in a handful of steps.
   task automatic program_random_settings(bit wild);
      int hi, lo, zg, zs;
      if (wild) begin
         program_settings(24'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
                          18'($urandom), 16'($urandom));
      end else begin
         hi = int'($urandom_range(131071));
         lo = -int'($urandom_range(131072));
         zg = lo + int'($urandom_range(hi - lo));
         zs = -((hi - lo) / int'($urandom_range(12, 2)) + 1);
         program_settings(24'($urandom), 18'(zg), 18'(lo), 18'(hi), 18'(zs), 16'($urandom));
      end
   endtask

   // A start first, then mostly samples just below the goal so that z
   // travels; some at / above the goal, starts, stops and junk codes.
   task automatic queue_random_items(int count);
      int pick;
      logic signed [23:0] s;
      queue_word(FUNC_START, 24'($urandom));
      repeat (count) begin
         pick = $urandom_range(99);
         s = 24'($urandom);
         if (pick < 4)
            queue_word(FUNC_START, s);
         else if (pick < 7)
            queue_word(FUNC_STOP, s);
         else if (pick < 9)
            queue_word(FuncUnused, s);
         else begin
            pick = $urandom_range(99);
            if (pick < 80)
               s = stim_goal - 24'(1 + $urandom_range(5000));
            else if (pick < 85)
               s = stim_goal;
            else if (pick < 88)
               s = stim_goal - 24'sd1;
            else if (pick < 94)
               s = stim_goal + 24'($urandom_range(5000));
            queue_word(FUNC_SAMPLE, s);
         end
      end
   endtask

   // Block is idle once every word went in and every response came out.
   task automatic wait_idle();
      do @(posedge clock);
      while (approach_req_q.size() != 0 || req_valid || approach_rsp_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: z walks down from +60000 in steps of 25000, floor -50000.
      program_settings(24'sd1000, 18'sd0, -18'sd50000, 18'sd60000, -18'sd25000, -16'sd7);
      queue_word(FUNC_SAMPLE, 24'sd5);          // sample while disarmed
      queue_word(FUNC_STOP, 24'sd0);            // stop while disarmed
      queue_word(FuncUnused, 24'sd0);           // junk code, disarmed
      queue_word(FUNC_START, 24'sd0);
      queue_word(FUNC_SAMPLE, 24'sd0);
      queue_word(FUNC_SAMPLE, -24'sd8388608);
      queue_word(FUNC_SAMPLE, 24'sd999);
      queue_word(FUNC_SAMPLE, -24'sd1);
      queue_word(FUNC_SAMPLE, 24'sd0);          // z drops past the floor
      queue_word(FUNC_SAMPLE, 24'sd0);          // floor hit: retract + stepper
      queue_word(FuncUnused, 24'sd0);           // junk code while armed
      queue_word(FUNC_START, 24'sd0);           // restart while armed
      queue_word(FUNC_SAMPLE, 24'sd1000);       // goal exactly, z above z goal
      queue_word(FUNC_START, 24'sd0);
      queue_word(FUNC_SAMPLE, 24'sd0);
      queue_word(FUNC_SAMPLE, 24'sd0);
      queue_word(FUNC_SAMPLE, 24'sd0);
      queue_word(FUNC_SAMPLE, 24'sd8388607);    // current reached, z below goal
      queue_word(FUNC_STOP, 24'sd0);
      wait_idle();

      // Extremes: clip at the top of the DAC range.
      program_settings(24'sd8388607, 18'sd131071, -18'sd131072, 18'sd131071,
                       18'sd131071, 16'sd32767);
      queue_word(FUNC_START, 24'sd0);
      queue_word(FUNC_SAMPLE, 24'sd0);
      queue_word(FUNC_SAMPLE, 24'sd8388607);
      wait_idle();

      // Extremes: clip at the bottom, then retract at the floor.
      program_settings(-24'sd8388608, -18'sd131072, -18'sd131072, -18'sd100000,
                       -18'sd131072, -16'sd32768);
      stim_goal = 24'sd8388607;   // keep samples below a goal that is now the maximum
      program_settings(24'sd8388607, 18'sd131071, -18'sd131072, -18'sd100000,
                       -18'sd131072, -16'sd32768);
      queue_word(FUNC_START, 24'sd0);
      queue_word(FUNC_SAMPLE, 24'sd0);
      queue_word(FUNC_SAMPLE, 24'sd0);
      wait_idle();

      // Random phases; idling cycles through none / sender / receiver / both.
      for (int p = 0; p < RandomPhases; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         program_random_settings(p == 3 || p == 6);
         queue_random_items(ItemsPerPhase);
         wait_idle();
      end

      // Back-pressure: receiver holds off while the sender keeps pushing,
      // so the response buffer fills and req_ready drops.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      program_random_settings(1'b0);
      @(negedge clock);
      hold_wanted = 1'b1;
      queue_random_items(30);
      wait_idle();

      repeat (5) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
